// ----- rtl/tlx_pkg.sv -----
package tlx_pkg;

    localparam int KW_NUM      = 8;
    localparam int KW_MAX      = 7;
    localparam int MAX_TOK     = 3;
    localparam int TOKQ_DEPTH  = 4;
    localparam int TOKQ_PTR_W  = $clog2(TOKQ_DEPTH);
    localparam int TOKQ_CNT_W  = $clog2(TOKQ_DEPTH + 1);

    typedef enum logic [4:0] {
        K_PROGRAM = 5'd0,
        K_BEGIN   = 5'd1,
        K_END     = 5'd2,
        K_INT_KW  = 5'd3,
        K_FLT_KW  = 5'd4,
        K_IF      = 5'd5,
        K_ELSE    = 5'd6,
        K_WHILE   = 5'd7,
        K_ID      = 5'd8,
        K_INT     = 5'd9,
        K_FLOAT   = 5'd10,
        K_STMT    = 5'd11,
        K_AND     = 5'd12,
        K_OR      = 5'd13,
        K_ADD     = 5'd14,
        K_MUL     = 5'd15,
        K_EQ      = 5'd16,
        K_REL     = 5'd17,
        K_ASSIGN  = 5'd18,
        K_OPEN    = 5'd19,
        K_CLOSE   = 5'd20,
        K_COMMA   = 5'd21,
        K_UNDEF   = 5'd22
    } t_kind;

    typedef enum logic [3:0] {
        M_IDLE,
        M_WORD,
        M_INT,
        M_INT_DOT,
        M_FRAC,
        M_AMP,
        M_BAR,
        M_BANG,
        M_COLON,
        M_REL
    } t_mode;

    typedef struct packed {
        t_mode mode;
        logic  emit;
        t_kind kind;
    } t_idle;

    typedef struct packed {
        logic [1:0]                n;
        t_kind [MAX_TOK-1:0]       kind;
    } t_scan_res;

    typedef struct packed {
        t_kind kind;
        logic  last;
    } t_tok;

    // keywords, left-justified, zero padded
    localparam logic [8*KW_MAX-1:0] KW_TEXT [KW_NUM] = '{
        "program",
        {"begin", 16'h0000},
        {"end",   32'h0000_0000},
        {"int",   32'h0000_0000},
        {"float", 16'h0000},
        {"if",    40'h00_0000_0000},
        {"else",  24'h00_0000},
        {"while", 16'h0000}
    };
    localparam int KW_LEN [KW_NUM] = '{7, 5, 3, 3, 5, 2, 4, 5};

    function automatic logic is_letter(input logic [7:0] b);
        return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return b >= "0" && b <= "9";
    endfunction

    function automatic logic is_space(input logic [7:0] b);
        return b == " " || (b >= 8'd9 && b <= 8'd13);
    endfunction

    function automatic t_idle scan_idle(input logic [7:0] b);
        t_idle r;
        r.mode = M_IDLE;
        r.emit = 1'b1;
        r.kind = K_UNDEF;
        if (is_letter(b)) begin
            r.mode = M_WORD;
            r.emit = 1'b0;
        end else if (is_digit(b)) begin
            r.mode = M_INT;
            r.emit = 1'b0;
        end else if (is_space(b)) begin
            r.emit = 1'b0;
        end else begin
            case (b) inside
                ";":           r.kind = K_STMT;
                "&": begin
                    r.mode = M_AMP;
                    r.emit = 1'b0;
                end
                "|": begin
                    r.mode = M_BAR;
                    r.emit = 1'b0;
                end
                "+", "-":      r.kind = K_ADD;
                "*", "/", "%": r.kind = K_MUL;
                "=":           r.kind = K_EQ;
                "!": begin
                    r.mode = M_BANG;
                    r.emit = 1'b0;
                end
                "<", ">": begin
                    r.mode = M_REL;
                    r.kind = K_REL;
                end
                ":": begin
                    r.mode = M_COLON;
                    r.emit = 1'b0;
                end
                "(":           r.kind = K_OPEN;
                ")":           r.kind = K_CLOSE;
                ",":           r.kind = K_COMMA;
                default:       r.kind = K_UNDEF;
            endcase
        end
        return r;
    endfunction

endpackage

// ----- rtl/tlx_if.sv -----
interface tlx_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_of_input;

    modport source (output valid, output in_byte, output end_of_input, input ready);
    modport sink   (input valid, input in_byte, input end_of_input, output ready);
endinterface

interface tlx_out_if;
    logic       valid;
    logic       ready;
    logic [4:0] token_kind;
    logic       last_of_run;

    modport source (output valid, output token_kind, output last_of_run, input ready);
    modport sink   (input valid, input token_kind, input last_of_run, output ready);
endinterface

// ----- rtl/tlx_scan.sv -----
module tlx_scan #(
    parameter int WORD_BUFFER_LEN = 7
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_accept,
    input  logic [7:0]           i_byte,
    input  logic                 i_eoi,
    output tlx_pkg::t_scan_res   o_res
);

    localparam int LEN_W = $clog2(WORD_BUFFER_LEN + 2);
    localparam int IDX_W = $clog2(WORD_BUFFER_LEN);

    tlx_pkg::t_mode  r_mode, n_mode;
    logic [LEN_W-1:0] r_len, n_len;
    logic [7:0]       r_chars [WORD_BUFFER_LEN];

    logic             w_en;
    logic [IDX_W-1:0] w_idx;
    tlx_pkg::t_kind   w_kind;
    logic             kw_hit;
    tlx_pkg::t_idle   idl;
    logic             rescan;
    logic [1:0]       pre_n;
    tlx_pkg::t_kind   pre_k0, pre_k1;
    tlx_pkg::t_mode   stay_mode;

    assign idl = tlx_pkg::scan_idle(i_byte);

    // keyword match of the buffered word
    always_comb begin
        w_kind = tlx_pkg::K_ID;
        kw_hit = 1'b0;
        for (int k = tlx_pkg::KW_NUM - 1; k >= 0; k--) begin
            kw_hit = (r_len == LEN_W'(tlx_pkg::KW_LEN[k]));
            for (int i = 0; i < tlx_pkg::KW_MAX; i++) begin
                if (i < tlx_pkg::KW_LEN[k]) begin
                    kw_hit = kw_hit && (r_chars[i] ==
                        tlx_pkg::KW_TEXT[k][8*(tlx_pkg::KW_MAX-1-i) +: 8]);
                end
            end
            if (kw_hit) begin
                w_kind = tlx_pkg::t_kind'(5'(k));
            end
        end
    end

    // step decode: tokens ended by this beat, and whether the byte is rescanned
    always_comb begin
        pre_n     = 2'd0;
        pre_k0    = tlx_pkg::K_UNDEF;
        pre_k1    = tlx_pkg::K_UNDEF;
        rescan    = 1'b0;
        stay_mode = r_mode;
        if (i_eoi) begin
            stay_mode = tlx_pkg::M_IDLE;
            unique case (r_mode) inside
                tlx_pkg::M_WORD: begin
                    pre_n  = 2'd1;
                    pre_k0 = w_kind;
                end
                tlx_pkg::M_INT: begin
                    pre_n  = 2'd1;
                    pre_k0 = tlx_pkg::K_INT;
                end
                tlx_pkg::M_INT_DOT: begin
                    pre_n  = 2'd2;
                    pre_k0 = tlx_pkg::K_INT;
                end
                tlx_pkg::M_FRAC: begin
                    pre_n  = 2'd1;
                    pre_k0 = tlx_pkg::K_FLOAT;
                end
                tlx_pkg::M_AMP, tlx_pkg::M_BAR, tlx_pkg::M_BANG, tlx_pkg::M_COLON: begin
                    pre_n = 2'd1;
                end
                default: ;
            endcase
        end else begin
            unique case (r_mode) inside
                tlx_pkg::M_WORD: begin
                    if (!tlx_pkg::is_letter(i_byte)) begin
                        pre_n  = 2'd1;
                        pre_k0 = w_kind;
                        rescan = 1'b1;
                    end
                end
                tlx_pkg::M_INT: begin
                    if (i_byte == ".") begin
                        stay_mode = tlx_pkg::M_INT_DOT;
                    end else if (!tlx_pkg::is_digit(i_byte)) begin
                        pre_n  = 2'd1;
                        pre_k0 = tlx_pkg::K_INT;
                        rescan = 1'b1;
                    end
                end
                tlx_pkg::M_INT_DOT: begin
                    if (tlx_pkg::is_digit(i_byte)) begin
                        stay_mode = tlx_pkg::M_FRAC;
                    end else begin
                        pre_n  = 2'd2;
                        pre_k0 = tlx_pkg::K_INT;
                        rescan = 1'b1;
                    end
                end
                tlx_pkg::M_FRAC: begin
                    if (!tlx_pkg::is_digit(i_byte)) begin
                        pre_n  = 2'd1;
                        pre_k0 = tlx_pkg::K_FLOAT;
                        rescan = 1'b1;
                    end
                end
                tlx_pkg::M_AMP, tlx_pkg::M_BAR, tlx_pkg::M_BANG, tlx_pkg::M_COLON: begin
                    pre_n = 2'd1;
                    if ((r_mode == tlx_pkg::M_AMP && i_byte == "&") ||
                        (r_mode == tlx_pkg::M_BAR && i_byte == "|") ||
                        (r_mode == tlx_pkg::M_BANG && i_byte == "=") ||
                        (r_mode == tlx_pkg::M_COLON && i_byte == "=")) begin
                        stay_mode = tlx_pkg::M_IDLE;
                        unique case (r_mode)
                            tlx_pkg::M_AMP:  pre_k0 = tlx_pkg::K_AND;
                            tlx_pkg::M_BAR:  pre_k0 = tlx_pkg::K_OR;
                            tlx_pkg::M_BANG: pre_k0 = tlx_pkg::K_EQ;
                            default:         pre_k0 = tlx_pkg::K_ASSIGN;
                        endcase
                    end else begin
                        rescan = 1'b1;
                    end
                end
                tlx_pkg::M_REL: begin
                    if (i_byte == "=") begin
                        stay_mode = tlx_pkg::M_IDLE;
                    end else begin
                        rescan = 1'b1;
                    end
                end
                default: rescan = 1'b1;
            endcase
        end
    end

    // next state
    always_comb begin
        n_mode = r_mode;
        n_len  = r_len;
        w_en   = 1'b0;
        w_idx  = '0;
        if (i_accept) begin
            n_mode = rescan ? idl.mode : stay_mode;
            if (i_eoi) begin
                n_len = '0;
            end else if (r_mode == tlx_pkg::M_WORD && tlx_pkg::is_letter(i_byte)) begin
                if (r_len < LEN_W'(WORD_BUFFER_LEN)) begin
                    w_en  = 1'b1;
                    w_idx = r_len[IDX_W-1:0];
                end
                if (r_len <= LEN_W'(WORD_BUFFER_LEN)) begin
                    n_len = r_len + LEN_W'(1);
                end
            end else if (rescan && idl.mode == tlx_pkg::M_WORD) begin
                w_en  = 1'b1;
                n_len = LEN_W'(1);
            end else if (rescan) begin
                n_len = '0;
            end
        end
    end

    // outputs
    always_comb begin
        o_res.kind[2] = tlx_pkg::K_UNDEF;
        o_res.kind[0] = pre_k0;
        o_res.kind[1] = pre_k1;
        if (pre_n == 2'd0) begin
            o_res.kind[0] = idl.kind;
        end else if (pre_n == 2'd1) begin
            o_res.kind[1] = idl.kind;
        end else begin
            o_res.kind[2] = idl.kind;
        end
        o_res.n = i_accept ? pre_n + {1'b0, rescan && idl.emit} : 2'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= tlx_pkg::M_IDLE;
            r_len  <= '0;
        end else begin
            r_mode <= n_mode;
            r_len  <= n_len;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_chars[w_idx] <= i_byte;
        end
    end

endmodule

// ----- rtl/tlx_tokq.sv -----
module tlx_tokq (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  tlx_pkg::t_scan_res i_res,
    output logic               o_room,
    tlx_out_if.source          o_out
);

    localparam int PTR_W = tlx_pkg::TOKQ_PTR_W;
    localparam int CNT_W = tlx_pkg::TOKQ_CNT_W;

    tlx_pkg::t_tok    r_mem [tlx_pkg::TOKQ_DEPTH];
    logic [PTR_W-1:0] r_wr, n_wr, r_rd, n_rd;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             pop;

    assign pop               = o_out.valid && o_out.ready;
    assign o_out.valid       = (r_cnt != '0);
    assign o_out.token_kind  = r_mem[r_rd].kind;
    assign o_out.last_of_run = r_mem[r_rd].last;
    assign o_room = (r_cnt <= CNT_W'(tlx_pkg::TOKQ_DEPTH - tlx_pkg::MAX_TOK));

    always_comb begin
        n_wr  = r_wr + PTR_W'(i_res.n);
        n_rd  = r_rd + PTR_W'(pop);
        n_cnt = r_cnt + CNT_W'(i_res.n) - CNT_W'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    // push up to three tokens per beat, flag the last one
    always_ff @(posedge i_clk) begin
        for (int j = 0; j < tlx_pkg::MAX_TOK; j++) begin
            if (2'(j) < i_res.n) begin
                r_mem[r_wr + PTR_W'(j)] <= '{kind: i_res.kind[j],
                                             last: (2'(j) == i_res.n - 2'd1)};
            end
        end
    end

    a_cnt_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(tlx_pkg::TOKQ_DEPTH))
        else $error("token queue over depth");

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_res.n != 2'd0) |-> o_room)
        else $error("tokens pushed without room");

    a_pop_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && i_res.n == 2'd0) |=> (r_cnt == $past(r_cnt) - CNT_W'(1)))
        else $error("token count off after pop");

endmodule

// ----- rtl/token_lexer.sv -----
// A token is written into the queue when the beat that ends it is accepted, and is
// offered on o_out from the queue head. Throughput: one byte per cycle while each
// byte yields at most one token and the sink takes one token per cycle; a byte
// that yields two or three tokens can stall the input, as the four-entry queue keeps room for three.
// Reset (i_rst_n low, synchronous): scanner idle, word length and queue cleared;
// the word buffer is not cleared.
module token_lexer #(
    parameter int WORD_BUFFER_LEN = 7
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    tlx_in_if.sink   i_in,
    tlx_out_if.source o_out
);

    tlx_pkg::t_scan_res res;
    logic               room;
    logic               accept;

    assign i_in.ready = room;
    assign accept     = i_in.valid && room;

    tlx_scan #(
        .WORD_BUFFER_LEN(WORD_BUFFER_LEN)
    ) u_scan (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_byte   (i_in.in_byte),
        .i_eoi    (i_in.end_of_input),
        .o_res    (res)
    );

    tlx_tokq u_tokq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_res   (res),
        .o_room  (room),
        .o_out   (o_out)
    );

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;

    typedef struct packed {
        logic [7:0]     b;
        logic           eoi;
        logic           typed;
        tlx_pkg::t_kind kind;
    } t_row;

    typedef struct packed {
        logic [7:0] b;
        logic       eoi;
    } t_beat;

    localparam int DIR_N = 25;
    localparam t_row DIR_ROWS [DIR_N] = '{
        '{8'h00, 1'b0, 1'b1, tlx_pkg::K_UNDEF},
        '{8'hFF, 1'b0, 1'b1, tlx_pkg::K_UNDEF},
        '{";",   1'b0, 1'b1, tlx_pkg::K_STMT},
        '{"(",   1'b0, 1'b1, tlx_pkg::K_OPEN},
        '{"i",   1'b0, 1'b0, tlx_pkg::K_UNDEF},
        '{"f",   1'b0, 1'b0, tlx_pkg::K_UNDEF},
        '{" ",   1'b0, 1'b0, tlx_pkg::K_UNDEF},
        '{"1",   1'b0, 1'b0, tlx_pkg::K_UNDEF},
        '{".",   1'b0, 1'b0, tlx_pkg::K_UNDEF},
        '{";",   1'b0, 1'b0, tlx_pkg::K_UNDEF},
        '{"<",   1'b0, 1'b1, tlx_pkg::K_REL},
        '{"=",   1'b0, 1'b0, tlx_pkg::K_UNDEF},
        '{"&",   1'b0, 1'b0, tlx_pkg::K_UNDEF},
        '{"a",   1'b0, 1'b0, tlx_pkg::K_UNDEF},
        '{"|",   1'b0, 1'b0, tlx_pkg::K_UNDEF},
        '{"|",   1'b0, 1'b0, tlx_pkg::K_UNDEF},
        '{":",   1'b0, 1'b0, tlx_pkg::K_UNDEF},
        '{"=",   1'b0, 1'b0, tlx_pkg::K_UNDEF},
        '{"!",   1'b0, 1'b0, tlx_pkg::K_UNDEF},
        '{8'hA5, 1'b1, 1'b0, tlx_pkg::K_UNDEF},
        '{"7",   1'b0, 1'b0, tlx_pkg::K_UNDEF},
        '{".",   1'b0, 1'b0, tlx_pkg::K_UNDEF},
        '{"5",   1'b0, 1'b0, tlx_pkg::K_UNDEF},
        '{8'hFF, 1'b1, 1'b0, tlx_pkg::K_UNDEF},
        '{8'h00, 1'b1, 1'b0, tlx_pkg::K_UNDEF}
    };

    localparam int PHASE_BEATS = 150;

    string kw_words [8] = '{"program", "begin", "end", "int", "float", "if", "else", "while"};
    string pair_ops [6] = '{"&&", "||", "!=", ":=", "<=", ">="};
    string punct = ";+-*/%=(),<>";
    string halves = "&|!:";

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    tlx_in_if  in_if ();
    tlx_out_if out_if ();

    token_lexer dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    always begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // scanner mirror
    tlx_pkg::t_mode lx_mode = tlx_pkg::M_IDLE;
    logic [7:0]     lx_word [7];
    logic [3:0]     lx_wlen = '0;
    tlx_pkg::t_kind lx_out [3];
    int             lx_n;

    tlx_pkg::t_tok tok_expect [$];
    t_beat chunk [$];
    int    n_errors = 0;
    int    n_tokens = 0;
    int    n_beats = 0;
    int    n_triples = 0;
    int    n_marks = 0;
    int    src_idle = 0;
    int    snk_idle = 0;

    function automatic logic lx_letter(input logic [7:0] b);
        return (b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A);
    endfunction

    function automatic logic lx_digit(input logic [7:0] b);
        return b >= 8'h30 && b <= 8'h39;
    endfunction

    function automatic logic lx_blank(input logic [7:0] b);
        return b == 8'h20 || (b >= 8'h09 && b <= 8'h0D);
    endfunction

    function automatic void note(input tlx_pkg::t_kind k);
        if (lx_n < 3) begin
            lx_out[lx_n] = k;
            lx_n++;
        end
    endfunction

    function automatic tlx_pkg::t_kind word_token();
        int   i;
        logic same;
        for (int k = 0; k < 8; k++) begin
            if (lx_wlen == kw_words[k].len()) begin
                same = 1'b1;
                for (i = 0; i < kw_words[k].len(); i++)
                    if (lx_word[i] != kw_words[k][i]) same = 1'b0;
                if (same) return tlx_pkg::t_kind'(k);
            end
        end
        return tlx_pkg::K_ID;
    endfunction

    function automatic void idle_scan(input logic [7:0] b);
        lx_mode = tlx_pkg::M_IDLE;
        if (lx_letter(b)) begin
            lx_word[0] = b;
            lx_wlen = 4'd1;
            lx_mode = tlx_pkg::M_WORD;
        end else if (lx_digit(b)) begin
            lx_mode = tlx_pkg::M_INT;
        end else if (!lx_blank(b)) begin
            case (b)
                ";":           note(tlx_pkg::K_STMT);
                "&":           lx_mode = tlx_pkg::M_AMP;
                "|":           lx_mode = tlx_pkg::M_BAR;
                "+", "-":      note(tlx_pkg::K_ADD);
                "*", "/", "%": note(tlx_pkg::K_MUL);
                "=":           note(tlx_pkg::K_EQ);
                "!":           lx_mode = tlx_pkg::M_BANG;
                "<", ">": begin
                    note(tlx_pkg::K_REL);
                    lx_mode = tlx_pkg::M_REL;
                end
                ":":           lx_mode = tlx_pkg::M_COLON;
                "(":           note(tlx_pkg::K_OPEN);
                ")":           note(tlx_pkg::K_CLOSE);
                ",":           note(tlx_pkg::K_COMMA);
                default:       note(tlx_pkg::K_UNDEF);
            endcase
        end
    endfunction

    function automatic void pair_close(input logic [7:0] b, input logic [7:0] partner,
                                       input tlx_pkg::t_kind k);
        if (b == partner) begin
            note(k);
            lx_mode = tlx_pkg::M_IDLE;
        end else begin
            note(tlx_pkg::K_UNDEF);
            idle_scan(b);
        end
    endfunction

    function automatic void lex_step(input logic [7:0] b, input logic eoi);
        lx_n = 0;
        if (eoi) begin
            case (lx_mode)
                tlx_pkg::M_WORD:    note(word_token());
                tlx_pkg::M_INT:     note(tlx_pkg::K_INT);
                tlx_pkg::M_INT_DOT: begin
                    note(tlx_pkg::K_INT);
                    note(tlx_pkg::K_UNDEF);
                end
                tlx_pkg::M_FRAC:    note(tlx_pkg::K_FLOAT);
                tlx_pkg::M_AMP, tlx_pkg::M_BAR, tlx_pkg::M_BANG, tlx_pkg::M_COLON:
                    note(tlx_pkg::K_UNDEF);
                default: ;
            endcase
            lx_mode = tlx_pkg::M_IDLE;
            lx_wlen = '0;
        end else begin
            case (lx_mode)
                tlx_pkg::M_WORD: begin
                    if (lx_letter(b)) begin
                        if (lx_wlen < 7) lx_word[lx_wlen] = b;
                        if (lx_wlen <= 7) lx_wlen++;
                    end else begin
                        note(word_token());
                        lx_wlen = '0;
                        idle_scan(b);
                    end
                end
                tlx_pkg::M_INT: begin
                    if (b == ".") begin
                        lx_mode = tlx_pkg::M_INT_DOT;
                    end else if (!lx_digit(b)) begin
                        note(tlx_pkg::K_INT);
                        idle_scan(b);
                    end
                end
                tlx_pkg::M_INT_DOT: begin
                    if (lx_digit(b)) begin
                        lx_mode = tlx_pkg::M_FRAC;
                    end else begin
                        note(tlx_pkg::K_INT);
                        note(tlx_pkg::K_UNDEF);
                        idle_scan(b);
                    end
                end
                tlx_pkg::M_FRAC: begin
                    if (!lx_digit(b)) begin
                        note(tlx_pkg::K_FLOAT);
                        idle_scan(b);
                    end
                end
                tlx_pkg::M_AMP:   pair_close(b, "&", tlx_pkg::K_AND);
                tlx_pkg::M_BAR:   pair_close(b, "|", tlx_pkg::K_OR);
                tlx_pkg::M_BANG:  pair_close(b, "=", tlx_pkg::K_EQ);
                tlx_pkg::M_COLON: pair_close(b, "=", tlx_pkg::K_ASSIGN);
                tlx_pkg::M_REL: begin
                    if (b == "=") lx_mode = tlx_pkg::M_IDLE;
                    else idle_scan(b);
                end
                default: idle_scan(b);
            endcase
        end
    endfunction

    task automatic report_mismatch(input string what);
        $display("MISMATCH @%0t: %s", $realtime, what);
        n_errors++;
    endtask

    // drive one beat from a falling edge; return at the falling edge after acceptance
    task automatic send_beat(input logic [7:0] b, input logic eoi, input logic typed,
                             input tlx_pkg::t_kind tk);
        while ($urandom_range(0, 99) < src_idle) begin
            in_if.valid = 1'b0;
            in_if.in_byte = 8'($urandom_range(0, 255));
            in_if.end_of_input = 1'($urandom_range(0, 1));
            @(negedge clk);
        end
        in_if.valid = 1'b1;
        in_if.in_byte = b;
        in_if.end_of_input = eoi;
        @(posedge clk);
        while (!in_if.ready) @(posedge clk);
        lex_step(b, eoi);
        n_beats++;
        if (eoi) n_marks++;
        if (lx_n == 3) n_triples++;
        if (typed) begin
            tok_expect.push_back('{tk, 1'b1});
        end else begin
            for (int i = 0; i < lx_n; i++)
                tok_expect.push_back('{lx_out[i], i == lx_n - 1});
        end
        @(negedge clk);
    endtask

    function automatic void add_byte(input logic [7:0] b);
        chunk.push_back('{b, 1'b0});
    endfunction

    function automatic logic [7:0] rand_letter();
        return ($urandom_range(0, 1) ? 8'h61 : 8'h41) + 8'($urandom_range(0, 25));
    endfunction

    function automatic logic [7:0] rand_digit();
        return 8'h30 + 8'($urandom_range(0, 9));
    endfunction

    function automatic logic [7:0] rand_non_digit();
        logic [7:0] c;
        do c = 8'($urandom_range(0, 255)); while (lx_digit(c));
        return c;
    endfunction

    // build one lexeme, mostly well formed, plus an optional separator
    function automatic void make_chunk();
        int         k;
        int         len;
        logic [7:0] c;
        case ($urandom_range(0, 13))
            0, 1, 2: begin
                k = $urandom_range(0, 7);
                for (int i = 0; i < kw_words[k].len(); i++) begin
                    c = kw_words[k][i];
                    if ($urandom_range(0, 15) == 0) c = c ^ 8'h20;
                    add_byte(c);
                end
            end
            3: begin
                len = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 12) : $urandom_range(1, 7);
                for (int i = 0; i < len; i++) add_byte(rand_letter());
            end
            4: begin
                k = $urandom_range(0, 7);
                len = kw_words[k].len();
                if ($urandom_range(0, 1)) len = len - 1;
                for (int i = 0; i < len; i++) add_byte(kw_words[k][i]);
                if (len == kw_words[k].len() || len == 0) add_byte(rand_letter());
            end
            5: begin
                len = $urandom_range(1, 4);
                for (int i = 0; i < len; i++) add_byte(rand_digit());
            end
            6: begin
                len = $urandom_range(1, 3);
                for (int i = 0; i < len; i++) add_byte(rand_digit());
                add_byte(".");
                len = $urandom_range(1, 3);
                for (int i = 0; i < len; i++) add_byte(rand_digit());
            end
            7: begin
                len = $urandom_range(1, 3);
                for (int i = 0; i < len; i++) add_byte(rand_digit());
                add_byte(".");
                if ($urandom_range(0, 3) == 0) chunk.push_back('{8'($urandom_range(0, 255)), 1'b1});
                else add_byte(rand_non_digit());
            end
            8: begin
                k = $urandom_range(0, 5);
                add_byte(pair_ops[k][0]);
                add_byte(pair_ops[k][1]);
            end
            9: begin
                add_byte(halves[$urandom_range(0, 3)]);
                if ($urandom_range(0, 3) == 0) chunk.push_back('{8'($urandom_range(0, 255)), 1'b1});
                else add_byte(8'($urandom_range(32, 126)));
            end
            10: add_byte(punct[$urandom_range(0, punct.len() - 1)]);
            11: add_byte($urandom_range(0, 6) == 0 ? 8'h20 : 8'($urandom_range(9, 13)));
            12: add_byte(8'($urandom_range(0, 255)));
            default: chunk.push_back('{8'($urandom_range(0, 255)), 1'b1});
        endcase
        if ($urandom_range(0, 1)) add_byte(8'h20);
    endfunction

    always @(negedge clk) begin
        out_if.ready = ($urandom_range(0, 99) >= snk_idle);
    end

    always @(posedge clk) begin
        tlx_pkg::t_tok want;
        if (rst_n && out_if.valid && out_if.ready) begin
            if (tok_expect.size() == 0) begin
                report_mismatch($sformatf("token kind %0d last %0b with none expected",
                                          out_if.token_kind, out_if.last_of_run));
            end else begin
                want = tok_expect.pop_front();
                n_tokens++;
                if (out_if.token_kind !== want.kind)
                    report_mismatch($sformatf("token_kind got %0d want %0d",
                                              out_if.token_kind, want.kind));
                if (out_if.last_of_run !== want.last)
                    report_mismatch($sformatf("last_of_run got %0b want %0b (kind %0d)",
                                              out_if.last_of_run, want.last, want.kind));
            end
        end
    end

    initial begin
        int   sent;
        logic drained;
        in_if.valid = 1'b0;
        in_if.in_byte = 8'h00;
        in_if.end_of_input = 1'b0;
        out_if.ready = 1'b0;
        drained = 1'b0;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;

        src_idle = 26;
        snk_idle = 56;
        for (int r = 0; r < DIR_N; r++)
            send_beat(DIR_ROWS[r].b, DIR_ROWS[r].eoi, DIR_ROWS[r].typed, DIR_ROWS[r].kind);

        for (int ph = 0; ph < 3; ph++) begin
            src_idle = (ph == 0) ? 26 : (ph == 1) ? 56 : 0;
            snk_idle = (ph == 0) ? 56 : (ph == 1) ? 26 : 0;
            sent = 0;
            while (sent < PHASE_BEATS) begin
                if (ph == 0 && !drained && sent >= PHASE_BEATS / 2) begin
                    // hold off until the output side has drained
                    in_if.valid = 1'b0;
                    while (tok_expect.size() != 0) @(negedge clk);
                    drained = 1'b1;
                end
                make_chunk();
                while (chunk.size() != 0) begin
                    t_beat bt;
                    bt = chunk.pop_front();
                    send_beat(bt.b, bt.eoi, 1'b0, tlx_pkg::K_UNDEF);
                    sent++;
                end
            end
        end
        in_if.valid = 1'b0;

        while (tok_expect.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);

        $display("summary: %0d bytes (%0d directed, %0d end marks) over three idling phases",
                 n_beats, DIR_N, n_marks);
        $display("summary: %0d tokens matched, %0d bytes gave three tokens, %0d mismatches",
                 n_tokens, n_triples, n_errors);
        if (n_errors == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

    initial begin
        #4_000_000;
        $display("timeout, %0d tokens still expected", tok_expect.size());
        $display("tb_top: errors");
        $finish;
    end

endmodule
